// ===== rtl/can_bus_health_monitor_unit_macros.svh =====
// Assertion helpers used by the monitor top level.
// Each helper checks a property on the rising edge of clk_i and stays quiet during reset.
`ifndef CAN_BUS_HEALTH_MONITOR_UNIT_MACROS_SVH
`define CAN_BUS_HEALTH_MONITOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbhm_pkg.sv =====
package cbhm_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  ThresholdRst  = 8'd3;
  localparam logic [15:0] TimeoutRst    = 16'd1000;
  localparam logic [3:0]  MaxRecovRst   = 4'd3;
  localparam logic [3:0]  RecovSat      = 4'd15;

  typedef enum logic [3:0] {
    ST_PENDING  = 4'd0,
    ST_OK       = 4'd1,
    ST_ACK_ERR  = 4'd2,
    ST_BUS_OFF  = 4'd3,
    ST_DISABLED = 4'd4,
    ST_STUFF    = 4'd5,
    ST_FORM     = 4'd6,
    ST_BIT1     = 4'd7,
    ST_BIT0     = 4'd8,
    ST_CRC      = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    LEC_NONE  = 3'd0,
    LEC_STUFF = 3'd1,
    LEC_FORM  = 3'd2,
    LEC_ACK   = 3'd3,
    LEC_BIT1  = 3'd4,
    LEC_BIT0  = 3'd5,
    LEC_CRC   = 3'd6,
    LEC_SAME  = 3'd7
  } lec_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_STOP    = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_MAX_RECOV = 2'd2
  } cfg_addr_e;

  // One controller poll; the first member sits in the top bits, so the
  // packing matches the input word from the lowest bit up in reverse order.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        rx_received;
    logic        tx_acked;
    logic        bus_off_flag;
    lec_e        error_code;
    logic [7:0]  rx_error_count;
    logic [7:0]  tx_error_count;
    logic        frame_queued;
    logic        controller_in_reset;
  } item_t;

  typedef struct packed {
    action_e     recovery_action;
    logic [2:0]  reported_error_code;
    logic [7:0]  reported_rx_errors;
    logic [7:0]  reported_tx_errors;
    logic [31:0] last_alive_ms;
    logic        bus_alive;
    status_e     health_status;
  } result_t;

  typedef struct packed {
    logic [7:0]  debounce_threshold;
    logic [15:0] ack_timeout_ms;
    logic [3:0]  max_recoveries;
  } cfg_t;

  function automatic status_e code_to_status(lec_e code);
    status_e st;
    case (code)
      LEC_NONE:  st = ST_OK;
      LEC_STUFF: st = ST_STUFF;
      LEC_FORM:  st = ST_FORM;
      LEC_ACK:   st = ST_ACK_ERR;
      LEC_BIT1:  st = ST_BIT1;
      LEC_BIT0:  st = ST_BIT0;
      LEC_CRC:   st = ST_CRC;
      default:   st = ST_PENDING;
    endcase
    return st;
  endfunction

endpackage

// ===== rtl/cbhm_core.sv =====
// Health state of the monitored controller and the decision for one poll.
// The result is combinational from the state and the poll; the state moves
// on when step_i is high.
module cbhm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cbhm_pkg::item_t  item_i,
  input  cbhm_pkg::cfg_t   cfg_i,
  output cbhm_pkg::result_t result_o
);

  logic                 tx_att_q, tx_att_d;
  logic                 ack_q, ack_d;
  logic [31:0]          last_q, last_d;
  cbhm_pkg::status_e    raw_q, raw_d;
  cbhm_pkg::status_e    filt_q, filt_d;
  logic [7:0]           stable_q, stable_d;
  logic [3:0]           recov_q, recov_d;
  cbhm_pkg::status_e    shown_q, shown_d;
  logic [7:0]           tx_err_q, tx_err_d;
  logic [7:0]           rx_err_q, rx_err_d;
  logic [2:0]           code_q, code_d;
  cbhm_pkg::status_e    raw_now;
  cbhm_pkg::action_e    action;
  logic [31:0]          elapsed;

  always_comb begin
    tx_att_d = tx_att_q;
    ack_d    = ack_q;
    last_d   = last_q;
    raw_d    = raw_q;
    filt_d   = filt_q;
    stable_d = stable_q;
    recov_d  = recov_q;
    shown_d  = shown_q;
    tx_err_d = tx_err_q;
    rx_err_d = rx_err_q;
    code_d   = code_q;
    raw_now  = cbhm_pkg::ST_PENDING;
    action   = cbhm_pkg::ACT_NONE;
    elapsed  = '0;

    if (item_i.controller_in_reset) begin
      shown_d = cbhm_pkg::ST_DISABLED;
    end else begin
      if (item_i.frame_queued) begin
        tx_att_d = 1'b1;
      end
      tx_err_d = item_i.tx_error_count;
      rx_err_d = item_i.rx_error_count;
      code_d   = item_i.error_code;
      if (item_i.tx_acked || item_i.rx_received) begin
        ack_d   = 1'b1;
        last_d  = item_i.now_ms;
        recov_d = '0;
      end
      if (item_i.bus_off_flag) begin
        shown_d = cbhm_pkg::ST_BUS_OFF;
        filt_d  = cbhm_pkg::ST_BUS_OFF;
        raw_d   = cbhm_pkg::ST_BUS_OFF;
        if (recov_d != cbhm_pkg::RecovSat) begin
          recov_d = recov_d + 4'd1;
        end
        if (recov_d > cfg_i.max_recoveries) begin
          action = cbhm_pkg::ACT_STOP;
        end else begin
          action   = cbhm_pkg::ACT_RESTART;
          ack_d    = 1'b0;
          tx_att_d = 1'b0;
          stable_d = '0;
        end
      end else begin
        elapsed = item_i.now_ms - last_d;
        if (!tx_att_d) begin
          raw_now = cbhm_pkg::ST_PENDING;
        end else if (!ack_d) begin
          if (item_i.error_code != cbhm_pkg::LEC_NONE &&
              item_i.error_code != cbhm_pkg::LEC_SAME) begin
            raw_now = cbhm_pkg::code_to_status(item_i.error_code);
          end else begin
            raw_now = cbhm_pkg::ST_ACK_ERR;
          end
        end else if (cfg_i.ack_timeout_ms != '0 &&
                     elapsed > {16'd0, cfg_i.ack_timeout_ms}) begin
          ack_d   = 1'b0;
          raw_now = cbhm_pkg::ST_ACK_ERR;
        end else begin
          raw_now = cbhm_pkg::ST_OK;
        end

        // Debounce: the filtered status follows only after enough equal
        // raw statuses in a row.
        if (raw_now == raw_q) begin
          if (stable_q < cfg_i.debounce_threshold) begin
            stable_d = stable_q + 8'd1;
          end
        end else begin
          raw_d    = raw_now;
          stable_d = 8'd1;
        end
        if (stable_d >= cfg_i.debounce_threshold) begin
          filt_d = raw_d;
        end
        shown_d = filt_d;
      end
    end

    result_o.health_status       = shown_d;
    result_o.bus_alive           = ack_d;
    result_o.last_alive_ms       = last_d;
    result_o.reported_tx_errors  = tx_err_d;
    result_o.reported_rx_errors  = rx_err_d;
    result_o.reported_error_code = code_d;
    result_o.recovery_action     = action;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_att_q <= 1'b0;
      ack_q    <= 1'b0;
      last_q   <= '0;
      raw_q    <= cbhm_pkg::ST_PENDING;
      filt_q   <= cbhm_pkg::ST_PENDING;
      stable_q <= '0;
      recov_q  <= '0;
      shown_q  <= cbhm_pkg::ST_PENDING;
      tx_err_q <= '0;
      rx_err_q <= '0;
      code_q   <= '0;
    end else if (step_i) begin
      tx_att_q <= tx_att_d;
      ack_q    <= ack_d;
      last_q   <= last_d;
      raw_q    <= raw_d;
      filt_q   <= filt_d;
      stable_q <= stable_d;
      recov_q  <= recov_d;
      shown_q  <= shown_d;
      tx_err_q <= tx_err_d;
      rx_err_q <= rx_err_d;
      code_q   <= code_d;
    end
  end

endmodule

// ===== rtl/can_bus_health_monitor_unit.sv =====
// A word accepted on the slave side passes through the input register and the result register to the master side.
// Throughput: one word per cycle; the input and result registers hand words on
// while the master side takes them.
// Reset (asynchronous, active low) empties both registers, clears the health state
// and loads the register defaults: debounce threshold 3, ACK timeout 1000 ms,
// maximum recoveries 3.
`include "can_bus_health_monitor_unit_macros.svh"

module can_bus_health_monitor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [cbhm_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [cbhm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Poll words in.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // From bit 0: controller_in_reset, frame_queued, tx_error_count[7:0],
  // rx_error_count[7:0], error_code[2:0], bus_off_flag, tx_acked,
  // rx_received, now_ms[31:0].
  input  logic [cbhm_pkg::InDataW-1:0]      s_axis_tdata,
  // Health reports out.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0: health_status[3:0], bus_alive, last_alive_ms[31:0],
  // reported_tx_errors[7:0], reported_rx_errors[7:0],
  // reported_error_code[2:0], recovery_action[1:0], zero fill to 64 bits.
  output logic [cbhm_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned ResultW = $bits(cbhm_pkg::result_t);

  // Configuration registers. Writes must only arrive while the block is idle, which the
  // block itself does not enforce; they get no synchronization with the word flow.
  cbhm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_threshold <= cbhm_pkg::ThresholdRst;
      cfg_q.ack_timeout_ms     <= cbhm_pkg::TimeoutRst;
      cfg_q.max_recoveries     <= cbhm_pkg::MaxRecovRst;
    end else if (cfg_we_i) begin
      case (cbhm_pkg::cfg_addr_e'(cfg_addr_i))
        cbhm_pkg::CFG_THRESHOLD: cfg_q.debounce_threshold <= cfg_wdata_i[7:0];
        cbhm_pkg::CFG_TIMEOUT:   cfg_q.ack_timeout_ms     <= cfg_wdata_i;
        cbhm_pkg::CFG_MAX_RECOV: cfg_q.max_recoveries     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Two register stages: the input register holds the poll, the result
  // register holds the finished report. The health state lives in the core
  // and advances exactly when a poll moves from the input register into the
  // result register, so every poll updates the state once and in order.
  logic              in_valid_q;
  cbhm_pkg::item_t   in_item_q;
  logic              out_valid_q;
  cbhm_pkg::result_t out_q;
  cbhm_pkg::result_t result;
  logic              advance;

  // The result register is free when it is empty or being drained this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= cbhm_pkg::item_t'(s_axis_tdata);
    end
  end

  cbhm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cbhm_pkg::OutDataW - ResultW){1'b0}}, out_q};

  // A poll held back by a full result register stays in the input register.
  `CBHM_ASSERT_NXT(a_in_hold, in_valid_q && !advance,
    in_valid_q && $stable(in_item_q), "input word lost while stalled")

  // Any recovery request only comes with a bus-off report.
  `CBHM_ASSERT_IMP(a_action_bus_off,
    out_valid_q && out_q.recovery_action != cbhm_pkg::ACT_NONE,
    out_q.health_status == cbhm_pkg::ST_BUS_OFF, "recovery action outside bus-off")

  // A restart drops the alive flag.
  `CBHM_ASSERT_IMP(a_restart_not_alive,
    out_valid_q && out_q.recovery_action == cbhm_pkg::ACT_RESTART,
    !out_q.bus_alive, "bus still alive after restart request")

  // A controller held in reset is reported disabled and gets no action.
  `CBHM_ASSERT_NXT(a_reset_disabled, advance && in_item_q.controller_in_reset,
    out_q.health_status == cbhm_pkg::ST_DISABLED &&
    out_q.recovery_action == cbhm_pkg::ACT_NONE, "reset poll not reported disabled")

endmodule

// ===== sim/can_bus_health_monitor_unit_test.sv =====
`timescale 1ns / 100ps

// Testbench for the CAN bus health monitor.
//
// Every poll word sent on the slave side yields exactly one health report word on the
// master side. A behavioral model of the monitor runs next to the block. It is updated
// at the edge where a poll is accepted, and the report it predicts is queued. Each
// report the block emits is popped from that queue and compared field by field.
//
// The run has two parts. The first is a short scripted sequence: reset defaults,
// controller reset, every error code, the ACK timeout boundary, a disabled timeout,
// a permanent stop, a saturating recovery limit and debounce thresholds of zero and
// 255. A few rows carry a hand-written report. The rest rely on the model. The second
// part is a set of random phases. Each phase sets its own register values and its own
// pattern of sender gaps and receiver stalls.
module can_bus_health_monitor_unit_test;

  localparam int unsigned ClkPeriod   = 2;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 85;

  // Register values per random phase. The extremes of every register are among them.
  localparam logic [7:0]  PhaseThr  [NumPhases] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd2, 8'd4};
  localparam logic [15:0] PhaseTmo  [NumPhases] = '{16'd1000, 16'd20, 16'd65535, 16'd1,
                                                    16'd0, 16'd300};
  localparam logic [3:0]  PhaseMaxR [NumPhases] = '{4'd3, 4'd0, 4'd15, 4'd7, 4'd15, 4'd1};

  typedef enum logic {
    ROW_POLL,
    ROW_WRITE
  } row_kind_e;

  // One row of the scripted sequence: either a register write or a poll word. A poll
  // row may carry a report typed in by hand. When it does not, the model supplies it.
  typedef struct packed {
    row_kind_e           kind;
    cbhm_pkg::cfg_addr_e reg_sel;
    logic [15:0]         reg_val;
    cbhm_pkg::item_t     poll;
    logic                typed;
    cbhm_pkg::result_t   want;
  } script_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cbhm_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [cbhm_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [cbhm_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [cbhm_pkg::OutDataW-1:0] m_axis_tdata;

  // Model copy of the registers.
  logic [7:0]  thr;
  logic [15:0] ack_tmo;
  logic [3:0]  max_rec;

  // Model copy of the health state.
  logic              tx_tried;
  logic              bus_seen;
  logic [31:0]       seen_tick;
  cbhm_pkg::status_e raw_st;
  cbhm_pkg::status_e filt_st;
  cbhm_pkg::status_e shown_st;
  logic [7:0]        stable_cnt;
  logic [3:0]        restarts;
  logic [7:0]        shown_tec;
  logic [7:0]        shown_rec;
  cbhm_pkg::lec_e    shown_lec;

  cbhm_pkg::result_t expected_reports[$];
  script_row_t       script[$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_cnt;

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // A long receiver hold-off is requested here and counted out by the receiver.
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;

  can_bus_health_monitor_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Works out the report for one accepted poll and advances the model state.
  task automatic compute_health_report(input cbhm_pkg::item_t p,
                                       output cbhm_pkg::result_t r);
    cbhm_pkg::status_e raw;
    cbhm_pkg::action_e act;
    act = cbhm_pkg::ACT_NONE;
    raw = cbhm_pkg::ST_PENDING;
    if (p.controller_in_reset) begin
      // A controller in reset only changes what is shown. Every other field is ignored.
      shown_st = cbhm_pkg::ST_DISABLED;
    end else begin
      if (p.frame_queued) begin
        tx_tried = 1'b1;
      end
      shown_tec = p.tx_error_count;
      shown_rec = p.rx_error_count;
      shown_lec = p.error_code;
      if (p.tx_acked || p.rx_received) begin
        bus_seen  = 1'b1;
        seen_tick = p.now_ms;
        restarts  = 4'd0;
      end
      if (p.bus_off_flag) begin
        shown_st = cbhm_pkg::ST_BUS_OFF;
        filt_st  = cbhm_pkg::ST_BUS_OFF;
        raw_st   = cbhm_pkg::ST_BUS_OFF;
        if (restarts != cbhm_pkg::RecovSat) begin
          restarts = restarts + 4'd1;
        end
        if (restarts > max_rec) begin
          // Out of restarts. The stop leaves the liveness state alone.
          act = cbhm_pkg::ACT_STOP;
        end else begin
          act        = cbhm_pkg::ACT_RESTART;
          bus_seen   = 1'b0;
          tx_tried   = 1'b0;
          stable_cnt = 8'd0;
        end
      end else begin
        if (!tx_tried) begin
          raw = cbhm_pkg::ST_PENDING;
        end else if (!bus_seen) begin
          case (p.error_code)
            cbhm_pkg::LEC_STUFF: raw = cbhm_pkg::ST_STUFF;
            cbhm_pkg::LEC_FORM:  raw = cbhm_pkg::ST_FORM;
            cbhm_pkg::LEC_BIT1:  raw = cbhm_pkg::ST_BIT1;
            cbhm_pkg::LEC_BIT0:  raw = cbhm_pkg::ST_BIT0;
            cbhm_pkg::LEC_CRC:   raw = cbhm_pkg::ST_CRC;
            // No error, an ACK error and an unchanged code all read as a missing ACK.
            default:             raw = cbhm_pkg::ST_ACK_ERR;
          endcase
        end else if (ack_tmo != 16'd0 && (p.now_ms - seen_tick) > 32'(ack_tmo)) begin
          // Elapsed time is taken modulo 2^32, so a wrapped tick still works.
          bus_seen = 1'b0;
          raw      = cbhm_pkg::ST_ACK_ERR;
        end else begin
          raw = cbhm_pkg::ST_OK;
        end
        if (raw == raw_st) begin
          if (stable_cnt < thr) begin
            stable_cnt = stable_cnt + 8'd1;
          end
        end else begin
          raw_st     = raw;
          stable_cnt = 8'd1;
        end
        if (stable_cnt >= thr) begin
          filt_st = raw_st;
        end
        shown_st = filt_st;
      end
    end
    r                     = '0;
    r.health_status       = shown_st;
    r.bus_alive           = bus_seen;
    r.last_alive_ms       = seen_tick;
    r.reported_tx_errors  = shown_tec;
    r.reported_rx_errors  = shown_rec;
    r.reported_error_code = shown_lec;
    r.recovery_action     = act;
  endtask

  function automatic script_row_t poll_row(logic rst, logic queued, logic [7:0] tec,
                                           logic [7:0] rec, cbhm_pkg::lec_e code,
                                           logic boff, logic acked, logic rxd,
                                           logic [31:0] now);
    script_row_t r;
    r                          = '0;
    r.kind                     = ROW_POLL;
    r.poll.controller_in_reset = rst;
    r.poll.frame_queued        = queued;
    r.poll.tx_error_count      = tec;
    r.poll.rx_error_count      = rec;
    r.poll.error_code          = code;
    r.poll.bus_off_flag        = boff;
    r.poll.tx_acked            = acked;
    r.poll.rx_received         = rxd;
    r.poll.now_ms              = now;
    return r;
  endfunction

  function automatic script_row_t typed_row(script_row_t r, cbhm_pkg::status_e st,
                                            logic alive, logic [31:0] last,
                                            logic [7:0] tec, logic [7:0] rec,
                                            cbhm_pkg::lec_e code,
                                            cbhm_pkg::action_e act);
    r.typed                    = 1'b1;
    r.want.health_status       = st;
    r.want.bus_alive           = alive;
    r.want.last_alive_ms       = last;
    r.want.reported_tx_errors  = tec;
    r.want.reported_rx_errors  = rec;
    r.want.reported_error_code = code;
    r.want.recovery_action     = act;
    return r;
  endfunction

  function automatic script_row_t write_row(cbhm_pkg::cfg_addr_e sel, logic [15:0] val);
    script_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // Offers one poll word. The task is entered at a falling edge and returns at the
  // falling edge after the word was taken, with tvalid still high.
  task automatic offer_poll(input cbhm_pkg::item_t p, input logic typed,
                            input cbhm_pkg::result_t typed_want);
    cbhm_pkg::result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_health_report(p, predicted);
    expected_reports.push_back(typed ? typed_want : predicted);
    @(negedge clk_i);
  endtask

  // Writes one register once the block has returned every report it owes.
  task automatic write_reg(input cbhm_pkg::cfg_addr_e sel, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= val;
    case (sel)
      cbhm_pkg::CFG_THRESHOLD: thr     = val[7:0];
      cbhm_pkg::CFG_TIMEOUT:   ack_tmo = val;
      cbhm_pkg::CFG_MAX_RECOV: max_rec = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // The receiver changes tready at the falling edge. A requested hold-off keeps it low
  // for a long stretch while the sender goes on offering words.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Report checker. The oldest queued report is matched against each word taken.
  always @(posedge clk_i) begin : report_check
    cbhm_pkg::result_t seen_report;
    cbhm_pkg::result_t want_report;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_report = m_axis_tdata[$bits(cbhm_pkg::result_t)-1:0];
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report word expected none, got %h", $time, m_axis_tdata);
      end else begin
        want_report = expected_reports.pop_front();
        compare_field("health_status", 32'(want_report.health_status),
                      32'(seen_report.health_status));
        compare_field("bus_alive", 32'(want_report.bus_alive), 32'(seen_report.bus_alive));
        compare_field("last_alive_ms", want_report.last_alive_ms, seen_report.last_alive_ms);
        compare_field("reported_tx_errors", 32'(want_report.reported_tx_errors),
                      32'(seen_report.reported_tx_errors));
        compare_field("reported_rx_errors", 32'(want_report.reported_rx_errors),
                      32'(seen_report.reported_rx_errors));
        compare_field("reported_error_code", 32'(want_report.reported_error_code),
                      32'(seen_report.reported_error_code));
        compare_field("recovery_action", 32'(want_report.recovery_action),
                      32'(seen_report.recovery_action));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    for (cycle_cnt = 0; cycle_cnt < CycleLimit; cycle_cnt++) @(posedge clk_i);
    $display("can_bus_health_monitor_unit_test: errors");
    $finish;
  end

  initial begin
    cbhm_pkg::item_t p;
    logic [63:0]     noise;
    int unsigned     tick;
    int unsigned     span;
    int unsigned     boff_left;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    thr        = cbhm_pkg::ThresholdRst;
    ack_tmo    = cbhm_pkg::TimeoutRst;
    max_rec    = cbhm_pkg::MaxRecovRst;
    tx_tried   = 1'b0;
    bus_seen   = 1'b0;
    seen_tick  = '0;
    raw_st     = cbhm_pkg::ST_PENDING;
    filt_st    = cbhm_pkg::ST_PENDING;
    shown_st   = cbhm_pkg::ST_PENDING;
    stable_cnt = 8'd0;
    restarts   = 4'd0;
    shown_tec  = 8'd0;
    shown_rec  = 8'd0;
    shown_lec  = cbhm_pkg::LEC_NONE;
    tick       = 0;
    boff_left  = 0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A controller in reset ignores every field, even when all but the error code are at their maximum.
    script.push_back(typed_row(poll_row(1'b1, 1'b1, 8'hFF, 8'hFF, cbhm_pkg::LEC_CRC,
                                        1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF),
                               cbhm_pkg::ST_DISABLED, 1'b0, 32'd0, 8'd0, 8'd0,
                               cbhm_pkg::LEC_NONE, cbhm_pkg::ACT_NONE));
    // No frame was ever queued, so the status stays pending. The counters are stored.
    script.push_back(typed_row(poll_row(1'b0, 1'b0, 8'hFF, 8'hFF, cbhm_pkg::LEC_SAME,
                                        1'b0, 1'b0, 1'b0, 32'd0),
                               cbhm_pkg::ST_PENDING, 1'b0, 32'd0, 8'hFF, 8'hFF,
                               cbhm_pkg::LEC_SAME, cbhm_pkg::ACT_NONE));
    // Bus-off together with an ACK: the ACK clears the recovery count first, then the
    // first restart is requested and liveness is dropped again.
    script.push_back(typed_row(poll_row(1'b0, 1'b1, 8'h00, 8'h80, cbhm_pkg::LEC_NONE,
                                        1'b1, 1'b1, 1'b0, 32'h8000_0000),
                               cbhm_pkg::ST_BUS_OFF, 1'b0, 32'h8000_0000, 8'h00, 8'h80,
                               cbhm_pkg::LEC_NONE, cbhm_pkg::ACT_RESTART));
    // Queued without an ACK. The default debounce needs three equal polls.
    repeat (3) script.push_back(poll_row(1'b0, 1'b1, 8'd1, 8'd2, cbhm_pkg::LEC_NONE,
                                         1'b0, 1'b0, 1'b0, 32'd10));
    script.push_back(write_row(cbhm_pkg::CFG_THRESHOLD, 16'd1));
    // Every error code is mapped while no ACK has been seen.
    script.push_back(poll_row(1'b0, 1'b0, 8'd3, 8'd3, cbhm_pkg::LEC_STUFF, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd4, 8'd4, cbhm_pkg::LEC_FORM, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd5, 8'd5, cbhm_pkg::LEC_ACK, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd6, 8'd6, cbhm_pkg::LEC_BIT1, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd7, 8'd7, cbhm_pkg::LEC_BIT0, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd8, 8'd8, cbhm_pkg::LEC_CRC, 1'b0, 1'b0, 1'b0,
                              32'd20));
    script.push_back(poll_row(1'b0, 1'b0, 8'd9, 8'd9, cbhm_pkg::LEC_SAME, 1'b0, 1'b0, 1'b0,
                              32'd30));
    // ACK, then RX, then polls right at and just past the timeout.
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b1, 1'b0,
                              32'd100));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b0, 1'b1,
                              32'd200));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b0, 1'b0,
                              32'd1200));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b0, 1'b0,
                              32'd1201));
    // With the timeout disabled, a huge gap still reads as OK.
    script.push_back(write_row(cbhm_pkg::CFG_TIMEOUT, 16'd0));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b1, 1'b0,
                              32'd5));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b0, 1'b0, 1'b0,
                              32'hFFFF_FFFF));
    // No restarts allowed: the first bus-off is a permanent stop.
    script.push_back(write_row(cbhm_pkg::CFG_MAX_RECOV, 16'd0));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b1, 1'b0, 1'b0,
                              32'd6));
    script.push_back(write_row(cbhm_pkg::CFG_MAX_RECOV, 16'd15));
    script.push_back(poll_row(1'b0, 1'b0, 8'd0, 8'd0, cbhm_pkg::LEC_NONE, 1'b1, 1'b1, 1'b0,
                              32'd7));
    // Threshold zero follows the raw status at once. Threshold 255 practically holds it.
    script.push_back(write_row(cbhm_pkg::CFG_THRESHOLD, 16'd0));
    script.push_back(poll_row(1'b0, 1'b1, 8'd0, 8'd0, cbhm_pkg::LEC_CRC, 1'b0, 1'b0, 1'b0,
                              32'd8));
    script.push_back(write_row(cbhm_pkg::CFG_THRESHOLD, 16'd255));
    repeat (2) script.push_back(poll_row(1'b0, 1'b1, 8'd0, 8'd0, cbhm_pkg::LEC_BIT1,
                                         1'b0, 1'b0, 1'b0, 32'd9));

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].reg_sel, script[i].reg_val);
      end else begin
        offer_poll(script[i].poll, script[i].typed, script[i].want);
      end
    end

    // Random phases. Most polls follow a plausible controller: a slowly advancing tick,
    // frequent ACKs and bursts of bus-off long enough to saturate the recovery count.
    // About one word in ten is raw noise.
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(cbhm_pkg::CFG_THRESHOLD, {8'd0, PhaseThr[ph]});
      write_reg(cbhm_pkg::CFG_TIMEOUT, PhaseTmo[ph]);
      write_reg(cbhm_pkg::CFG_MAX_RECOV, {12'd0, PhaseMaxR[ph]});
      case (ph % 4)
        1: begin
          idle_pct  = 62;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 62;
        end
        3: begin
          idle_pct  = 26;
          stall_pct = 26;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        tick = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 4 && n == 20) begin
          hold_req = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          noise = {$urandom, $urandom};
          p     = noise[cbhm_pkg::InDataW-1:0];
        end else begin
          span = (ack_tmo == 16'd0) ? 2000 : 32'(ack_tmo) / 2 + 2;
          if ($urandom_range(0, 19) == 0) begin
            tick = $urandom;
          end else begin
            tick = tick + $urandom_range(0, span);
          end
          p                     = '0;
          p.controller_in_reset = ($urandom_range(0, 15) == 0);
          p.frame_queued        = ($urandom_range(0, 1) == 1);
          p.tx_error_count      = 8'($urandom_range(0, 255));
          p.rx_error_count      = 8'($urandom_range(0, 255));
          p.error_code          = cbhm_pkg::lec_e'(3'($urandom_range(0, 7)));
          p.tx_acked            = ($urandom_range(0, 2) == 0);
          p.rx_received         = ($urandom_range(0, 3) == 0);
          p.now_ms              = tick;
          if (boff_left == 0 && $urandom_range(0, 24) == 0) begin
            boff_left = $urandom_range(1, 18);
          end
          if (boff_left != 0) begin
            boff_left--;
            p.bus_off_flag = 1'b1;
            p.tx_acked     = ($urandom_range(0, 7) == 0);
            p.rx_received  = 1'b0;
          end
        end
        offer_poll(p, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("can_bus_health_monitor_unit_test: clean");
    end else begin
      $display("can_bus_health_monitor_unit_test: errors");
    end
    $finish;
  end

endmodule
